[rtl/core/smmc_pkg.sv]
// ----------------------------------------------------------------------------
// smmc_pkg
// Shared widths, types and codes of the subarray mean match counter.
// ----------------------------------------------------------------------------
package smmc_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COUNT_W     = 20;
    localparam int MAX_LENGTH  = 1024;
    localparam int WINDOW_BITS = 12;
    localparam int EPOCH_BITS  = 8;

    // samples in one sequence, up to MAX_LENGTH itself
    localparam int ITEMS_W     = $clog2(MAX_LENGTH + 1);
    // running prefix: MAX_LENGTH differences of SAMPLE_W+1 bits each
    localparam int PREFIX_W    = SAMPLE_W + 1 + $clog2(MAX_LENGTH);
    localparam int TABLE_DEPTH = 1 << WINDOW_BITS;

    // front-to-back queue
    localparam int MQ_DEPTH    = 4;
    localparam int MQ_PTR_W    = $clog2(MQ_DEPTH);
    localparam int MQ_CNT_W    = $clog2(MQ_DEPTH + 1);

    // result queue
    localparam int OQ_DEPTH    = 4;
    localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 2);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first;
    } smmc_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] run_count;
        logic               out_of_window;
    } smmc_out_t;

    // one classified item, as the back part carries it out
    typedef struct packed {
        logic [WINDOW_BITS-1:0] idx;
        logic                   lookup;
        logic                   zero;
        logic                   first;
        logic                   sweep;
        logic [EPOCH_BITS-1:0]  epoch;
        logic                   window_flag;
    } smmc_op_t;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] tag;
        logic [ITEMS_W-1:0]    count;
    } smmc_entry_t;

    typedef enum logic {
        BK_SWEEP,
        BK_RUN
    } smmc_back_state_t;

endpackage

[rtl/core/smmc_front.sv]
// ----------------------------------------------------------------------------
// smmc_front
// Accepts items, keeps the running prefix, length and epoch of the sequence
// and turns each item into a table operation for the back part.
// ----------------------------------------------------------------------------
module smmc_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic signed [smmc_pkg::SAMPLE_W-1:0] cfg_wr_data,
    input  logic                                 accept,
    input  smmc_pkg::smmc_in_t                   in_item,
    output smmc_pkg::smmc_op_t                   op
);

    logic signed [smmc_pkg::SAMPLE_W-1:0]  target_reg;
    logic signed [smmc_pkg::PREFIX_W-1:0]  prefix_reg;
    logic signed [smmc_pkg::PREFIX_W-1:0]  prefix_next;
    logic [smmc_pkg::ITEMS_W-1:0]          items_reg;
    logic [smmc_pkg::ITEMS_W-1:0]          items_next;
    logic [smmc_pkg::EPOCH_BITS-1:0]       epoch_reg;
    logic [smmc_pkg::EPOCH_BITS-1:0]       epoch_next;
    logic                                  flag_reg;
    logic                                  flag_next;

    logic signed [smmc_pkg::PREFIX_W-1:0]  prefix_base;
    logic [smmc_pkg::ITEMS_W-1:0]          items_base;
    logic                                  flag_base;
    logic signed [smmc_pkg::SAMPLE_W:0]    diff;
    logic signed [smmc_pkg::PREFIX_W-1:0]  prefix_sum;
    logic [smmc_pkg::PREFIX_W-smmc_pkg::WINDOW_BITS:0] upper;
    logic                                  full_len;
    logic                                  in_win;

    always_comb
    begin
        // a new sequence starts from an empty prefix in the next epoch
        epoch_next  = in_item.first ? epoch_reg + 1'b1 : epoch_reg;
        prefix_base = in_item.first ? '0 : prefix_reg;
        items_base  = in_item.first ? '0 : items_reg;
        flag_base   = in_item.first ? 1'b0 : flag_reg;

        diff       = {in_item.sample[smmc_pkg::SAMPLE_W-1], in_item.sample}
                   - {target_reg[smmc_pkg::SAMPLE_W-1], target_reg};
        prefix_sum = prefix_base
                   + {{(smmc_pkg::PREFIX_W-smmc_pkg::SAMPLE_W-1){diff[smmc_pkg::SAMPLE_W]}},
                      diff};

        full_len = (items_base >= smmc_pkg::ITEMS_W'(smmc_pkg::MAX_LENGTH));
        upper    = prefix_sum[smmc_pkg::PREFIX_W-1:smmc_pkg::WINDOW_BITS-1];
        in_win   = (upper == '0) || (upper == '1);

        prefix_next = full_len ? prefix_base : prefix_sum;
        items_next  = full_len ? items_base : items_base + 1'b1;
        flag_next   = flag_base | full_len | ~in_win;

        // offset by half the window: flip the window's top bit
        op.idx         = {~prefix_sum[smmc_pkg::WINDOW_BITS-1],
                          prefix_sum[smmc_pkg::WINDOW_BITS-2:0]};
        op.lookup      = ~full_len & in_win;
        op.zero        = (prefix_sum == '0);
        op.first       = in_item.first;
        op.sweep       = in_item.first && (epoch_next == '0);
        op.epoch       = epoch_next;
        op.window_flag = flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            prefix_reg <= '0;
            items_reg  <= '0;
            epoch_reg  <= '0;
            flag_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                target_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                prefix_reg <= prefix_next;
                items_reg  <= items_next;
                epoch_reg  <= epoch_next;
                flag_reg   <= flag_next;
            end
        end
    end

endmodule

[rtl/core/smmc_queue.sv]
// ----------------------------------------------------------------------------
// smmc_queue
// Short queue of table operations between the front and back parts.
// ----------------------------------------------------------------------------
module smmc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  smmc_pkg::smmc_op_t push_op,
    output logic               full,
    input  logic               pop,
    output smmc_pkg::smmc_op_t head_op,
    output logic               empty
);

    smmc_pkg::smmc_op_t              slot_reg [smmc_pkg::MQ_DEPTH];
    logic [smmc_pkg::MQ_PTR_W-1:0]   wr_ptr_reg;
    logic [smmc_pkg::MQ_PTR_W-1:0]   rd_ptr_reg;
    logic [smmc_pkg::MQ_CNT_W-1:0]   cnt_reg;
    logic [smmc_pkg::MQ_CNT_W-1:0]   cnt_next;
    logic                            do_push;
    logic                            do_pop;

    assign full    = (cnt_reg == smmc_pkg::MQ_CNT_W'(smmc_pkg::MQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head_op = slot_reg[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= smmc_pkg::MQ_CNT_W'(smmc_pkg::MQ_DEPTH))
        else $error("operation queue count out of range");

endmodule

[rtl/core/smmc_back.sv]
// ----------------------------------------------------------------------------
// smmc_back
// Clears the tally table and carries out table operations: tally table read,
// update with forwarding, running match count, and the result queue.
// ----------------------------------------------------------------------------
module smmc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  smmc_pkg::smmc_op_t  q_op,
    input  logic                q_empty,
    output logic                q_pop,
    output smmc_pkg::smmc_out_t out_item,
    output logic                empty,
    input  logic                pop
);

    smmc_pkg::smmc_back_state_t        state_reg;
    smmc_pkg::smmc_back_state_t        state_next;
    logic [smmc_pkg::WINDOW_BITS-1:0]  sweep_cnt_reg;
    logic                              sweep_done_reg;
    logic                              sweep_last;
    logic                              sweep_wr;
    logic                              room;
    logic                              issue;

    smmc_pkg::smmc_entry_t             mem [smmc_pkg::TABLE_DEPTH];
    smmc_pkg::smmc_entry_t             rd_data_reg;
    smmc_pkg::smmc_entry_t             fwd_data_reg;
    logic                              fwd_hit_reg;
    logic                              wr_en;
    logic [smmc_pkg::WINDOW_BITS-1:0]  wr_addr;
    smmc_pkg::smmc_entry_t             wr_data;

    smmc_pkg::smmc_op_t                b_op_reg;
    logic                              b_valid_reg;
    smmc_pkg::smmc_entry_t             entry;
    logic [smmc_pkg::ITEMS_W-1:0]      have;
    logic [smmc_pkg::ITEMS_W-1:0]      add;
    logic [smmc_pkg::COUNT_W-1:0]      base;
    logic [smmc_pkg::COUNT_W:0]        sum_wide;
    logic [smmc_pkg::COUNT_W-1:0]      match_reg;
    logic [smmc_pkg::COUNT_W-1:0]      match_next;

    smmc_pkg::smmc_out_t               oq_reg [smmc_pkg::OQ_DEPTH];
    logic [smmc_pkg::OQ_PTR_W-1:0]     oq_wr_ptr_reg;
    logic [smmc_pkg::OQ_PTR_W-1:0]     oq_rd_ptr_reg;
    logic [smmc_pkg::OQ_CNT_W-1:0]     oq_cnt_reg;
    logic                              oq_pop;

    // ---------------------------------------------------------------- control
    assign sweep_last = (sweep_cnt_reg == '1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smmc_pkg::BK_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = smmc_pkg::BK_RUN;
                end
            end
            smmc_pkg::BK_RUN:
            begin
                if (!q_empty && q_op.sweep && !sweep_done_reg)
                begin
                    state_next = smmc_pkg::BK_SWEEP;
                end
            end
            default:
            begin
                state_next = smmc_pkg::BK_SWEEP;
            end
        endcase
    end

    always_comb
    begin
        // hold issue until the result queue surely has a slot for it
        room = (smmc_pkg::OQ_CNT_W'(oq_cnt_reg) + smmc_pkg::OQ_CNT_W'(b_valid_reg))
             < smmc_pkg::OQ_CNT_W'(smmc_pkg::OQ_DEPTH);
        sweep_wr = 1'b0;
        issue    = 1'b0;
        unique case (state_reg)
            smmc_pkg::BK_SWEEP:
            begin
                sweep_wr = 1'b1;
            end
            smmc_pkg::BK_RUN:
            begin
                issue = !q_empty && room && (!q_op.sweep || sweep_done_reg);
            end
            default:
            begin
                sweep_wr = 1'b0;
                issue    = 1'b0;
            end
        endcase
    end

    assign q_pop = issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= smmc_pkg::BK_SWEEP;
            sweep_cnt_reg  <= '0;
            sweep_done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (sweep_wr)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            end
            if (sweep_wr && sweep_last)
            begin
                sweep_done_reg <= 1'b1;
            end
            else if (issue)
            begin
                sweep_done_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------ tally table
    always_comb
    begin
        entry = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        have  = (entry.tag == b_op_reg.epoch) ? entry.count : '0;
        // the empty prefix counts once toward a zero prefix
        add   = have + smmc_pkg::ITEMS_W'(b_op_reg.zero);
        base  = b_op_reg.first ? '0 : match_reg;

        sum_wide = {1'b0, base} + (smmc_pkg::COUNT_W+1)'(add);
        if (!b_op_reg.lookup)
        begin
            match_next = base;
        end
        else if (sum_wide[smmc_pkg::COUNT_W])
        begin
            match_next = '1;
        end
        else
        begin
            match_next = sum_wide[smmc_pkg::COUNT_W-1:0];
        end

        if (sweep_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en         = b_valid_reg & b_op_reg.lookup;
            wr_addr       = b_op_reg.idx;
            wr_data.tag   = b_op_reg.epoch;
            wr_data.count = have + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg  <= mem[q_op.idx];
            // the write in this cycle is not yet in the read data
            fwd_hit_reg  <= wr_en && (wr_addr == q_op.idx);
            fwd_data_reg <= wr_data;
            b_op_reg     <= q_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            match_reg   <= '0;
        end
        else
        begin
            b_valid_reg <= issue;
            if (b_valid_reg)
            begin
                match_reg <= match_next;
            end
        end
    end

    // ----------------------------------------------------------- result queue
    assign empty    = (oq_cnt_reg == '0);
    assign out_item = oq_reg[oq_rd_ptr_reg];
    assign oq_pop   = pop & ~empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_cnt_reg    <= '0;
        end
        else
        begin
            if (b_valid_reg)
            begin
                oq_wr_ptr_reg <= oq_wr_ptr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                oq_rd_ptr_reg <= oq_rd_ptr_reg + 1'b1;
            end
            if (b_valid_reg && !oq_pop)
            begin
                oq_cnt_reg <= oq_cnt_reg + 1'b1;
            end
            else if (oq_pop && !b_valid_reg)
            begin
                oq_cnt_reg <= oq_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
        begin
            oq_reg[oq_wr_ptr_reg].run_count     <= match_next;
            oq_reg[oq_wr_ptr_reg].out_of_window <= b_op_reg.window_flag;
        end
    end

    // ------------------------------------------------------------- assertions
    a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (oq_cnt_reg < smmc_pkg::OQ_CNT_W'(smmc_pkg::OQ_DEPTH)))
        else $error("result queue written while full");

    a_sweep_port: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == smmc_pkg::BK_SWEEP) |-> !b_valid_reg)
        else $error("table update collides with clearing pass");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !b_op_reg.first) |-> (match_next >= match_reg))
        else $error("match count fell within a sequence");

endmodule

[rtl/core/subarray_mean_match_counter.sv]
// ----------------------------------------------------------------------------
// subarray_mean_match_counter
// Counts contiguous runs whose mean equals a configured target.
// ----------------------------------------------------------------------------
// Takes one item per clock while full is low and returns one result per item,
// in order, via the operation queue, an issue register and the result queue.
// The rate is set by the tally table, read when an item issues and written
// back in the cycle after with one entry of forwarding, so back-to-back items
// on the same prefix run at full speed. After reset, and on every new sequence
// that wraps the 8-bit epoch (every 256th sequence), the 4096-entry table is
// cleared; items are still taken until the 4-entry operation queue fills,
// then full stays high until the clearing pass ends. target_average is
// written through cfg_wr_en/cfg_wr_data and must only change while idle.
// ----------------------------------------------------------------------------
module subarray_mean_match_counter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic signed [smmc_pkg::SAMPLE_W-1:0] cfg_wr_data,
    input  logic                                 push,
    input  smmc_pkg::smmc_in_t                   in_item,
    output logic                                 full,
    output logic                                 empty,
    input  logic                                 pop,
    output smmc_pkg::smmc_out_t                  out_item
);

    smmc_pkg::smmc_op_t front_op;
    smmc_pkg::smmc_op_t head_op;
    logic               accept;
    logic               q_empty;
    logic               q_pop;

    assign accept = push & ~full;

    smmc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .in_item     (in_item),
        .op          (front_op)
    );

    smmc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .push_op (front_op),
        .full    (full),
        .pop     (q_pop),
        .head_op (head_op),
        .empty   (q_empty)
    );

    smmc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_op     (head_op),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .out_item (out_item),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the subarray mean match counter.
// ----------------------------------------------------------------------------
// Sequences of samples go through a queue-fed driver. A behavioral copy of
// the prefix tally table predicts the running count and sticky window flag
// for every accepted item. A monitor compares each popped result in order.
// The phases cover the following:
//   - directed corners at target zero and at the target extremes
//   - random sequences under several idle and stall patterns
//   - enough short sequences to wrap the epoch
//   - one over-long sequence that drives the count to its peak
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int REPORT_LIMIT   = 40;
    localparam int RANDOM_ITEMS   = 50;
    localparam int TABLE_HALF     = smmc_pkg::TABLE_DEPTH / 2;
    localparam int EPOCH_COUNT    = 1 << smmc_pkg::EPOCH_BITS;
    localparam int SAMPLE_MAX     = (1 << (smmc_pkg::SAMPLE_W - 1)) - 1;
    localparam int SAMPLE_MIN     = -(1 << (smmc_pkg::SAMPLE_W - 1));
    localparam int unsigned COUNT_MAX = (1 << smmc_pkg::COUNT_W) - 1;

    logic                                 clk         = 1'b0;
    logic                                 rst_n       = 1'b0;
    logic                                 cfg_wr_en   = 1'b0;
    logic signed [smmc_pkg::SAMPLE_W-1:0] cfg_wr_data = '0;
    logic                                 push        = 1'b0;
    smmc_pkg::smmc_in_t                   in_item     = '0;
    logic                                 full;
    logic                                 empty;
    logic                                 pop         = 1'b0;
    smmc_pkg::smmc_out_t                  out_item;

    // stimulus and expectations
    smmc_pkg::smmc_in_t  sample_queue [$];
    smmc_pkg::smmc_out_t expected_counts [$];
    bit        push_taken;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_request;
    int        hold_left;
    int        idle_cycles;
    int        error_count;
    int        items_accepted;
    int        sequences_started;
    int        epoch_wraps;
    int        peak_count;

    // predictor state
    longint      target_avg;
    longint      prefix_sum;
    int unsigned match_count;
    int          seq_len;
    int          cur_epoch;
    bit          window_sticky;
    int          tally_tag [smmc_pkg::TABLE_DEPTH];
    int unsigned tally_cnt [smmc_pkg::TABLE_DEPTH];

    subarray_mean_match_counter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .in_item     (in_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .out_item    (out_item)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic smmc_pkg::smmc_out_t predict_run_count(smmc_pkg::smmc_in_t it);
        longint              slot;
        int unsigned         have;
        int unsigned         total;
        int                  i;
        smmc_pkg::smmc_out_t res;
        if (it.first)
        begin
            prefix_sum    = 0;
            match_count   = 0;
            seq_len       = 0;
            window_sticky = 1'b0;
            cur_epoch     = (cur_epoch + 1) % EPOCH_COUNT;
            // wrapped epoch: the whole table is swept clear
            if (cur_epoch == 0)
            begin
                epoch_wraps++;
                for (i = 0; i < smmc_pkg::TABLE_DEPTH; i++)
                begin
                    tally_tag[i] = 0;
                    tally_cnt[i] = 0;
                end
            end
        end
        if (seq_len >= smmc_pkg::MAX_LENGTH)
        begin
            window_sticky = 1'b1;
        end
        else
        begin
            seq_len++;
            prefix_sum += longint'($signed(it.sample)) - target_avg;
            slot = prefix_sum + TABLE_HALF;
            if (slot < 0 || slot >= smmc_pkg::TABLE_DEPTH)
            begin
                window_sticky = 1'b1;
            end
            else
            begin
                have  = (tally_tag[slot] == cur_epoch) ? tally_cnt[slot] : 0;
                // the empty prefix counts as one earlier zero prefix
                total = match_count + have + ((prefix_sum == 0) ? 1 : 0);
                match_count     = (total > COUNT_MAX) ? COUNT_MAX : total;
                tally_tag[slot] = cur_epoch;
                tally_cnt[slot] = have + 1;
            end
        end
        res.run_count     = match_count[smmc_pkg::COUNT_W-1:0];
        res.out_of_window = window_sticky;
        return res;
    endfunction

    function automatic void queue_sample(int value, bit first);
        smmc_pkg::smmc_in_t it;
        it.sample = value[smmc_pkg::SAMPLE_W-1:0];
        it.first  = first;
        if (first)
            sequences_started++;
        sample_queue.push_back(it);
    endfunction

    function automatic int near_target(int spread);
        int v;
        v = int'(target_avg) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        else if (v < SAMPLE_MIN)
            v = SAMPLE_MIN;
        return v;
    endfunction

    // mostly well-formed sequences near the target, some wide, some noise
    function automatic void queue_random(int count);
        int made;
        int kind;
        int len;
        int k;
        made = 0;
        while (made < count)
        begin
            kind = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
            for (k = 0; k < len; k++)
            begin
                if (kind < 75)
                    queue_sample(near_target(3), k == 0);
                else if (kind < 90)
                    queue_sample(near_target(700), k == 0);
                else
                    queue_sample($urandom_range(0, 65535), $urandom_range(0, 3) == 0);
            end
            made += len;
        end
    endfunction

    task automatic wait_drained();
        while (sample_queue.size() != 0 || expected_counts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_target(int value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[smmc_pkg::SAMPLE_W-1:0];
        target_avg   = longint'($signed(value[smmc_pkg::SAMPLE_W-1:0]));
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // sender: hold an offered item until taken, else offer the next one
    always @(negedge clk)
    begin
        if (!(push && !push_taken))
        begin
            if (rst_n && sample_queue.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                push    <= 1'b1;
                in_item <= sample_queue[0];
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else
        begin
            pop <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // accept, predict, check and watch for a stuck block
    always @(posedge clk)
    begin
        smmc_pkg::smmc_out_t want;
        bit                  popped;
        if (rst_n)
        begin
            push_taken = push && !full;
            popped     = pop && !empty;
            if (push_taken)
            begin
                expected_counts.push_back(predict_run_count(in_item));
                void'(sample_queue.pop_front());
                items_accepted++;
            end
            if (popped)
            begin
                if (expected_counts.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result with none expected: run_count %0d out_of_window %0b",
                             $time, out_item.run_count, out_item.out_of_window);
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (out_item.run_count > peak_count)
                        peak_count = out_item.run_count;
                    if (out_item.run_count !== want.run_count)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: run_count expected %0d actual %0d",
                                     $time, want.run_count, out_item.run_count);
                    end
                    if (out_item.out_of_window !== want.out_of_window)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: out_of_window expected %0b actual %0b",
                                     $time, want.out_of_window, out_item.out_of_window);
                    end
                end
            end
            if (push_taken || popped)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                         $time, idle_cycles, expected_counts.size());
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed corners at target zero
        write_target(0);
        queue_sample(5, 1'b0);
        queue_sample(-5, 1'b0);
        queue_sample(0, 1'b1);
        queue_sample(0, 1'b0);
        queue_sample(SAMPLE_MAX, 1'b0);
        queue_sample(SAMPLE_MIN, 1'b0);
        queue_sample(SAMPLE_MIN, 1'b1);
        queue_sample(TABLE_HALF - 1, 1'b1);
        queue_sample(1, 1'b0);
        queue_sample(-TABLE_HALF, 1'b1);
        queue_sample(-1, 1'b0);
        queue_sample(0, 1'b1);
        queue_sample(3, 1'b0);
        queue_sample(-3, 1'b0);
        wait_drained();

        // target extremes
        write_target(SAMPLE_MAX);
        queue_sample(SAMPLE_MAX, 1'b1);
        queue_sample(SAMPLE_MAX, 1'b0);
        queue_sample(SAMPLE_MIN, 1'b0);
        wait_drained();
        write_target(SAMPLE_MIN);
        queue_sample(SAMPLE_MIN, 1'b1);
        queue_sample(SAMPLE_MAX, 1'b0);
        queue_sample(SAMPLE_MIN, 1'b1);
        wait_drained();

        // random sequences under idle and stall patterns
        send_idle_pct  = 45;
        recv_stall_pct = 0;
        write_target($urandom_range(0, 65535));
        queue_random(RANDOM_ITEMS);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 45;
        write_target($urandom_range(0, 65535));
        queue_random(RANDOM_ITEMS);
        wait_drained();

        send_idle_pct  = 29;
        recv_stall_pct = 29;
        write_target($urandom_range(0, 65535));
        queue_random(RANDOM_ITEMS);
        wait_drained();

        // short sequences to wrap the epoch; receiver holds off first
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_target($urandom_range(0, 65535));
        hold_request = 150;
        while (sequences_started < EPOCH_COUNT + 4)
        begin
            queue_sample(near_target(1), 1'b1);
            if ($urandom_range(0, 3) == 0)
                queue_sample(near_target(1), 1'b0);
        end
        wait_drained();

        // every run matches until the sequence overruns its length
        write_target(SAMPLE_MIN);
        for (i = 0; i < smmc_pkg::MAX_LENGTH + 3; i++)
            queue_sample(SAMPLE_MIN, i == 0);
        queue_sample(SAMPLE_MIN, 1'b1);
        wait_drained();

        $display("summary: %0d items in %0d sequences, %0d epoch wraps, peak run_count %0d",
                 items_accepted, sequences_started, epoch_wraps, peak_count);
        $display("summary: %0d mismatches", error_count);
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/smmc_pkg.sv
rtl/core/smmc_front.sv
rtl/core/smmc_queue.sv
rtl/core/smmc_back.sv
rtl/core/subarray_mean_match_counter.sv
sim/testbench.sv
